// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtt smoothing estimator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define RSE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rse check failed");
// clocked check that also holds through reset
`define RSE_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rse check failed");
`else
`define RSE_ASSERT(label, clk, rst_n, prop)
`define RSE_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/rse_pkg.sv =====
// shared constants for the rtt smoothing estimator
// no dependencies
`default_nettype none

package rse_pkg;

  // default datapath sizing
  localparam int RTT_BITS   = 32;
  localparam int FRAC_BITS  = 8;
  localparam int GAIN_SHIFT = 3;

  // bank memory geometry
  localparam int NUM_BANKS = 2;
  localparam int BANK_W    = 1;

  // fixed beat field widths
  localparam int RTT_IN_W  = 32;
  localparam int SM_OUT_W  = 40;
  localparam int MIN_OUT_W = 32;

  // item operations
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

endpackage

`default_nettype wire

// ===== sv/rse_chan_if.sv =====
// valid/ready channel interfaces for sample beats and result beats
// depends on rse_pkg
`default_nettype none

interface rse_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [rse_pkg::BANK_W-1:0]    bank;
  logic [rse_pkg::RTT_IN_W-1:0]  new_rtt;

  modport source (output valid, output op, output bank, output new_rtt, input ready);
  modport sink   (input valid, input op, input bank, input new_rtt, output ready);
endinterface

interface rse_out_if;
  logic                           valid;
  logic                           ready;
  logic [rse_pkg::BANK_W-1:0]     bank_out;
  logic [rse_pkg::SM_OUT_W-1:0]   srtt;
  logic [rse_pkg::SM_OUT_W-1:0]   srtt_step;
  logic [rse_pkg::SM_OUT_W-1:0]   rtt_var;
  logic [rse_pkg::SM_OUT_W-1:0]   rtt_var_step;
  logic [rse_pkg::MIN_OUT_W-1:0]  min_rtt;
  logic [rse_pkg::MIN_OUT_W-1:0]  min_rtt_step;
  logic [rse_pkg::MIN_OUT_W-1:0]  latest_rtt;

  modport source (output valid, output bank_out, output srtt, output srtt_step,
                  output rtt_var, output rtt_var_step, output min_rtt,
                  output min_rtt_step, output latest_rtt, input ready);
  modport sink   (input valid, input bank_out, input srtt, input srtt_step,
                  input rtt_var, input rtt_var_step, input min_rtt,
                  input min_rtt_step, input latest_rtt, output ready);
endinterface

`default_nettype wire

// ===== sv/rse_state_ram.sv =====
// per-bank state memory, one write and one registered read port
// depends on rse_pkg; entries read as zero until first written after reset
`default_nettype none

module rse_state_ram #(
  parameter int DATA_W = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [rse_pkg::BANK_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]          wr_data,
  input  wire logic                       rd_en,
  input  wire logic [rse_pkg::BANK_W-1:0] rd_addr,
  output logic      [DATA_W-1:0]          rd_data
);

  logic [DATA_W-1:0]             mem_r [rse_pkg::NUM_BANKS];
  logic [rse_pkg::NUM_BANKS-1:0] valid_r;
  logic [DATA_W-1:0]             rd_data_r;
  logic                          rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // entry valid bits stand in for the reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== sv/rse_update.sv =====
// combinational update of one bank's state for a sample or restart beat
// depends on rse_pkg for gain shift and op codes
`default_nettype none

module rse_update #(
  parameter int RTT_BITS  = rse_pkg::RTT_BITS,
  parameter int FRAC_BITS = rse_pkg::FRAC_BITS
) (
  input  wire logic                          op,
  input  wire logic [RTT_BITS-1:0]           rtt,
  input  wire logic [RTT_BITS+FRAC_BITS-1:0] cur_sg,
  input  wire logic [RTT_BITS+FRAC_BITS-1:0] cur_ss,
  input  wire logic [RTT_BITS+FRAC_BITS-1:0] cur_dg,
  input  wire logic [RTT_BITS+FRAC_BITS-1:0] cur_ds,
  input  wire logic [RTT_BITS-1:0]           cur_mg,
  input  wire logic [RTT_BITS-1:0]           cur_ms,
  input  wire logic [RTT_BITS-1:0]           cur_last,
  output logic      [RTT_BITS+FRAC_BITS-1:0] new_sg,
  output logic      [RTT_BITS+FRAC_BITS-1:0] new_ss,
  output logic      [RTT_BITS+FRAC_BITS-1:0] new_dg,
  output logic      [RTT_BITS+FRAC_BITS-1:0] new_ds,
  output logic      [RTT_BITS-1:0]           new_mg,
  output logic      [RTT_BITS-1:0]           new_ms,
  output logic      [RTT_BITS-1:0]           new_last
);

  localparam int SmW = RTT_BITS + FRAC_BITS;

  // v + ((t - v) >>> gain), floor on the signed step
  function automatic logic [SmW-1:0] move_toward(input logic [SmW-1:0] v,
                                                 input logic [SmW-1:0] t);
    logic signed [SmW:0] diff;
    logic signed [SmW:0] sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, v});
    sum  = $signed({1'b0, v}) + (diff >>> rse_pkg::GAIN_SHIFT);
    return sum[SmW-1:0];
  endfunction

  function automatic logic [SmW-1:0] abs_diff(input logic [SmW-1:0] a,
                                              input logic [SmW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [RTT_BITS-1:0] take_min(input logic [RTT_BITS-1:0] m,
                                                   input logic [RTT_BITS-1:0] s);
    return (m == '0 || s < m) ? s : m;
  endfunction

  logic [SmW-1:0] x;
  logic [SmW-1:0] err_g;
  logic [SmW-1:0] err_s;

  assign x     = {rtt, {FRAC_BITS{1'b0}}};
  assign err_g = abs_diff(x, cur_sg);
  assign err_s = abs_diff(x, cur_ss);

  always_comb begin
    new_sg   = cur_sg;
    new_ss   = '0;
    new_dg   = cur_dg;
    new_ds   = '0;
    new_mg   = cur_mg;
    new_ms   = '0;
    new_last = cur_last;
    if (op == rse_pkg::OP_SAMPLE) begin
      new_sg   = (cur_sg == '0) ? x : move_toward(cur_sg, x);
      new_ss   = (cur_ss == '0) ? x : move_toward(cur_ss, x);
      new_dg   = (cur_dg == '0) ? (err_g >> rse_pkg::GAIN_SHIFT)
                                : move_toward(cur_dg, err_g);
      new_ds   = (cur_ds == '0) ? err_s : move_toward(cur_ds, err_s);
      new_mg   = take_min(cur_mg, rtt);
      new_ms   = take_min(cur_ms, rtt);
      new_last = rtt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtt_smoothing_estimator.sv =====
// rtt smoothing estimator top level: bank state memory, update stage, result register
// depends on rse_pkg, rse_chan_if, rse_state_ram, rse_update and assert_macros.svh
//
// usage:
//   in_ch carries one beat per item: op (sample or restart), bank (data or
//   header) and new_rtt. out_ch returns exactly one beat per item with the
//   selected bank's smoothed rtts, mean deviations, minimums and latest rtt
//   after the update, in acceptance order.
//   flow: an item is held in the update stage, then its result is registered
//   for out_ch; the update is a single read-modify-write pass on the bank
//   memory (registered read, compute, write back). throughput: one item per
//   cycle while no result stalls, back to back on either bank; a same-bank
//   follower takes the just-written word from a forwarding register.
//   stall: while the result register is held by a stalled receiver the item
//   in the update stage waits and in_ch.ready drops once that stage is full;
//   one new item is still taken while a result waits.
//   reset: rst_n low for one edge clears the pipeline and the entry valid
//   bits; both banks then read as all zero, so no clearing pass is needed
//   and items are accepted on the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"

module rtt_smoothing_estimator #(
  parameter int RTT_BITS  = rse_pkg::RTT_BITS,
  parameter int FRAC_BITS = rse_pkg::FRAC_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rse_in_if.sink    in_ch,
  rse_out_if.source out_ch
);

  localparam int SmW    = RTT_BITS + FRAC_BITS;
  localparam int WordW  = 4 * SmW + 3 * RTT_BITS;
  localparam int SmOutW = rse_pkg::SM_OUT_W;
  localparam int MinOutW = rse_pkg::MIN_OUT_W;

  // one memory word holds a whole bank
  typedef struct packed {
    logic [SmW-1:0]      sg;
    logic [SmW-1:0]      ss;
    logic [SmW-1:0]      dg;
    logic [SmW-1:0]      ds;
    logic [RTT_BITS-1:0] mg;
    logic [RTT_BITS-1:0] ms;
    logic [RTT_BITS-1:0] last;
  } word_t;

  // handshake
  logic in_fire;
  logic s1_adv;
  logic out_fire;

  // update stage
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_op_r;
  logic [rse_pkg::BANK_W-1:0] s1_bank_r;
  logic [RTT_BITS-1:0]        s1_rtt_r;

  // forwarding of the word written at the edge this item was read
  logic  fwd_hit_r;
  logic  fwd_hit_nxt;
  word_t fwd_word_r;

  logic [WordW-1:0] rd_data;
  word_t            rd_word;
  word_t            cur_word;
  word_t            new_word;

  // result register
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [rse_pkg::BANK_W-1:0] out_bank_r;
  logic [SmOutW-1:0]          out_sg_r;
  logic [SmOutW-1:0]          out_ss_r;
  logic [SmOutW-1:0]          out_dg_r;
  logic [SmOutW-1:0]          out_ds_r;
  logic [MinOutW-1:0]         out_mg_r;
  logic [MinOutW-1:0]         out_ms_r;
  logic [MinOutW-1:0]         out_last_r;

  // stage moves on when the result register is empty or being drained
  assign out_fire     = out_valid_r && out_ch.ready;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_fire);
  // the write from the leaving item lands after the read of the entering one
  assign fwd_hit_nxt   = s1_adv && (s1_bank_r == in_ch.bank);

  rse_state_ram #(
    .DATA_W (WordW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_adv),
    .wr_addr (s1_bank_r),
    .wr_data (new_word),
    .rd_en   (in_fire),
    .rd_addr (in_ch.bank),
    .rd_data (rd_data)
  );

  assign rd_word  = rd_data;
  assign cur_word = fwd_hit_r ? fwd_word_r : rd_word;

  rse_update #(
    .RTT_BITS  (RTT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_update (
    .op       (s1_op_r),
    .rtt      (s1_rtt_r),
    .cur_sg   (cur_word.sg),
    .cur_ss   (cur_word.ss),
    .cur_dg   (cur_word.dg),
    .cur_ds   (cur_word.ds),
    .cur_mg   (cur_word.mg),
    .cur_ms   (cur_word.ms),
    .cur_last (cur_word.last),
    .new_sg   (new_word.sg),
    .new_ss   (new_word.ss),
    .new_dg   (new_word.dg),
    .new_ds   (new_word.ds),
    .new_mg   (new_word.mg),
    .new_ms   (new_word.ms),
    .new_last (new_word.last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        fwd_hit_r <= fwd_hit_nxt;
      end
    end
  end

  // stage payload, held while the stage waits
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_ch.op;
      s1_bank_r  <= in_ch.bank;
      s1_rtt_r   <= RTT_BITS'(in_ch.new_rtt);
      fwd_word_r <= new_word;
    end
  end

  // result payload, narrowed or widened to the beat fields
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bank_r <= s1_bank_r;
      out_sg_r   <= SmOutW'(new_word.sg);
      out_ss_r   <= SmOutW'(new_word.ss);
      out_dg_r   <= SmOutW'(new_word.dg);
      out_ds_r   <= SmOutW'(new_word.ds);
      out_mg_r   <= MinOutW'(new_word.mg);
      out_ms_r   <= MinOutW'(new_word.ms);
      out_last_r <= MinOutW'(new_word.last);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bank_out     = out_bank_r;
  assign out_ch.srtt         = out_sg_r;
  assign out_ch.srtt_step    = out_ss_r;
  assign out_ch.rtt_var      = out_dg_r;
  assign out_ch.rtt_var_step = out_ds_r;
  assign out_ch.min_rtt      = out_mg_r;
  assign out_ch.min_rtt_step = out_ms_r;
  assign out_ch.latest_rtt   = out_last_r;

  // an accepted beat always occupies the update stage next
  `RSE_ASSERT(a_fire_fills_stage, clk, rst_n, in_fire |=> s1_valid_r)
  // a waiting item keeps its bank
  `RSE_ASSERT(a_stall_holds_bank, clk, rst_n, (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_bank_r)))
  // a finished item lands in the result register for its own bank
  `RSE_ASSERT(a_result_bank, clk, rst_n, s1_adv |=> (out_ch.valid && out_ch.bank_out == $past(s1_bank_r)))
  // a restart reports cleared step values
  `RSE_ASSERT(a_restart_clears, clk, rst_n, (s1_adv && s1_op_r == rse_pkg::OP_RESTART) |=> (out_ch.srtt_step == '0 && out_ch.rtt_var_step == '0 && out_ch.min_rtt_step == '0))
  // nothing is offered right after a reset edge
  `RSE_ASSERT_NR(a_reset_empty, clk, !rst_n |=> (!out_ch.valid && !s1_valid_r))

endmodule

`default_nettype wire

// ===== tb/rtt_smoothing_estimator_test.sv =====
// self-checking testbench for rtt_smoothing_estimator: random valid/ready traffic on both channels
// depends on rse_pkg, rse_chan_if and the rtl top; a built-in bank model predicts every result beat
`timescale 1ns / 100ps

module rtt_smoothing_estimator_test;

  // package values used here
  localparam int   RTT_BITS   = rse_pkg::RTT_BITS;
  localparam int   FRAC_BITS  = rse_pkg::FRAC_BITS;
  localparam int   GAIN_SHIFT = rse_pkg::GAIN_SHIFT;
  localparam int   BANK_W     = rse_pkg::BANK_W;
  localparam int   RTT_IN_W   = rse_pkg::RTT_IN_W;
  localparam int   SM_OUT_W   = rse_pkg::SM_OUT_W;
  localparam int   MIN_OUT_W  = rse_pkg::MIN_OUT_W;
  localparam logic OP_SAMPLE  = rse_pkg::OP_SAMPLE;
  localparam logic OP_RESTART = rse_pkg::OP_RESTART;

  // bank selects as carried in the bank field
  localparam logic [BANK_W-1:0] BANK_DATA   = 1'b0;
  localparam logic [BANK_W-1:0] BANK_HEADER = 1'b1;

  // smoothed values carry the rtt plus its fraction bits
  localparam int SM_W = RTT_BITS + FRAC_BITS;

  localparam int          RANDOM_BEATS = 1250;
  localparam longint      RTT_TOP      = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic              op;
    logic [BANK_W-1:0] bank;
    logic [RTT_IN_W-1:0] new_rtt;
    bit                drain_first;  // sender waits for all results before this beat
  } rtt_beat_t;

  typedef struct {
    logic [BANK_W-1:0]    bank;
    logic [SM_OUT_W-1:0]  srtt;
    logic [SM_OUT_W-1:0]  srtt_step;
    logic [SM_OUT_W-1:0]  rtt_var;
    logic [SM_OUT_W-1:0]  rtt_var_step;
    logic [MIN_OUT_W-1:0] min_rtt;
    logic [MIN_OUT_W-1:0] min_rtt_step;
    logic [MIN_OUT_W-1:0] latest_rtt;
  } rtt_report_t;

  bit   clk;
  logic rst_n = 1'b0;

  rse_in_if  in_ch ();
  rse_out_if out_ch ();

  rtt_smoothing_estimator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // beats waiting to be sent, and reports waiting to come back
  rtt_beat_t   sample_feed[$];
  rtt_report_t want_reports[$];

  int unsigned total_beats;
  int unsigned beats_taken;
  int unsigned mismatch_count;
  bit          in_taken;  // input beat accepted at the last rising edge

  // per-bank estimator state, all zero means unset
  logic [SM_W-1:0]     srtt_glob[2];
  logic [SM_W-1:0]     srtt_stp[2];
  logic [SM_W-1:0]     dev_glob[2];
  logic [SM_W-1:0]     dev_stp[2];
  logic [RTT_BITS-1:0] floor_glob[2];
  logic [RTT_BITS-1:0] floor_stp[2];
  logic [RTT_BITS-1:0] last_rtt[2];

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // gain of 1/8: step toward target by the difference shifted arithmetically,
  // so a falling value moves down by the ceiling of one eighth
  function automatic logic [SM_W-1:0] nudge(input logic [SM_W-1:0] cur,
                                            input logic [SM_W-1:0] target);
    logic signed [SM_W+1:0] delta;
    delta = $signed({2'b00, target}) - $signed({2'b00, cur});
    return cur + SM_W'(delta >>> GAIN_SHIFT);
  endfunction

  function automatic logic [SM_W-1:0] abs_gap(input logic [SM_W-1:0] a,
                                              input logic [SM_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // folds one accepted beat into the bank state and returns the report it causes
  function automatic rtt_report_t fold_beat(input rtt_beat_t bt);
    rtt_report_t     rep;
    logic [SM_W-1:0] scaled;
    logic [SM_W-1:0] err_g;
    logic [SM_W-1:0] err_s;
    logic            b;
    b = bt.bank;
    if (bt.op == OP_SAMPLE) begin
      scaled = {{FRAC_BITS{1'b0}}, bt.new_rtt[RTT_BITS-1:0]} << FRAC_BITS;
      // both errors against the smoothed values before this sample
      err_g = abs_gap(scaled, srtt_glob[b]);
      err_s = abs_gap(scaled, srtt_stp[b]);
      srtt_glob[b] = (srtt_glob[b] == '0) ? scaled : nudge(srtt_glob[b], scaled);
      srtt_stp[b]  = (srtt_stp[b] == '0) ? scaled : nudge(srtt_stp[b], scaled);
      // first global deviation is a fraction of the error, first step deviation all of it
      dev_glob[b]  = (dev_glob[b] == '0) ? (err_g >> GAIN_SHIFT) : nudge(dev_glob[b], err_g);
      dev_stp[b]   = (dev_stp[b] == '0) ? err_s : nudge(dev_stp[b], err_s);
      // a zero sample on an unset minimum keeps it unset
      if (floor_glob[b] == '0 || bt.new_rtt < floor_glob[b]) floor_glob[b] = bt.new_rtt;
      if (floor_stp[b] == '0 || bt.new_rtt < floor_stp[b]) floor_stp[b] = bt.new_rtt;
      last_rtt[b] = bt.new_rtt;
    end else begin
      // restart clears step values only
      srtt_stp[b]  = '0;
      dev_stp[b]   = '0;
      floor_stp[b] = '0;
    end
    rep.bank         = bt.bank;
    rep.srtt         = srtt_glob[b];
    rep.srtt_step    = srtt_stp[b];
    rep.rtt_var      = dev_glob[b];
    rep.rtt_var_step = dev_stp[b];
    rep.min_rtt      = floor_glob[b];
    rep.min_rtt_step = floor_stp[b];
    rep.latest_rtt   = last_rtt[b];
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [SM_OUT_W-1:0] want,
                                      input logic [SM_OUT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // idle length: mostly none or short, a few long, none at all in a steady stretch
  function automatic int unsigned idle_len(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 64);
  endfunction

  // scoreboard: result beats checked against the oldest report, accepted input
  // beats folded into the predictor
  always @(posedge clk) begin
    rtt_report_t got;
    rtt_report_t want;
    rtt_beat_t   bt;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.bank         = out_ch.bank_out;
        got.srtt         = out_ch.srtt;
        got.srtt_step    = out_ch.srtt_step;
        got.rtt_var      = out_ch.rtt_var;
        got.rtt_var_step = out_ch.rtt_var_step;
        got.min_rtt      = out_ch.min_rtt;
        got.min_rtt_step = out_ch.min_rtt_step;
        got.latest_rtt   = out_ch.latest_rtt;
        if (want_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, bank %0d srtt %h latest %h",
                   $time, got.bank, got.srtt, got.latest_rtt);
        end else begin
          want = want_reports.pop_front();
          check_field("bank_out", SM_OUT_W'(want.bank), SM_OUT_W'(got.bank));
          check_field("srtt", want.srtt, got.srtt);
          check_field("srtt_step", want.srtt_step, got.srtt_step);
          check_field("rtt_var", want.rtt_var, got.rtt_var);
          check_field("rtt_var_step", want.rtt_var_step, got.rtt_var_step);
          check_field("min_rtt", SM_OUT_W'(want.min_rtt), SM_OUT_W'(got.min_rtt));
          check_field("min_rtt_step", SM_OUT_W'(want.min_rtt_step),
                      SM_OUT_W'(got.min_rtt_step));
          check_field("latest_rtt", SM_OUT_W'(want.latest_rtt), SM_OUT_W'(got.latest_rtt));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bt.op          = in_ch.op;
        bt.bank        = in_ch.bank;
        bt.new_rtt     = in_ch.new_rtt;
        bt.drain_first = 1'b0;
        want_reports.insert(want_reports.size(), fold_beat(bt));
        beats_taken++;
        in_taken = 1'b1;
      end
    end
  end

  // sender: holds a beat until taken, then idles or presents the next one
  int unsigned send_gap;
  bit          send_steady;

  always @(negedge clk) begin
    rtt_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_feed.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (sample_feed[0].drain_first && want_reports.size() != 0) begin
        // hold off until every outstanding result has come back
        in_ch.valid <= 1'b0;
      end else begin
        nxt = sample_feed.pop_front();
        in_ch.op      <= nxt.op;
        in_ch.bank    <= nxt.bank;
        in_ch.new_rtt <= nxt.new_rtt;
        in_ch.valid   <= 1'b1;
        send_gap = idle_len(send_steady);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      end
    end
  end

  // receiver: random back-pressure with occasional steady stretches
  int unsigned stall_left;
  bit          recv_steady;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = idle_len(recv_steady);
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
    end
  end

  task automatic add_beat(input logic op, input logic [BANK_W-1:0] bank,
                          input logic [RTT_IN_W-1:0] rtt, input bit drain);
    rtt_beat_t bt;
    bt.op          = op;
    bt.bank        = bank;
    bt.new_rtt     = rtt;
    bt.drain_first = drain;
    sample_feed.insert(sample_feed.size(), bt);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned       directed_n;
    int unsigned       run_len;
    logic [BANK_W-1:0] bk;
    longint            base;
    longint            spread;
    longint            v;

    in_ch.valid   = 1'b0;
    in_ch.op      = OP_SAMPLE;
    in_ch.bank    = BANK_DATA;
    in_ch.new_rtt = '0;
    out_ch.ready  = 1'b0;
    for (int i = 0; i < 2; i++) begin
      srtt_glob[i]  = '0;
      srtt_stp[i]   = '0;
      dev_glob[i]   = '0;
      dev_stp[i]    = '0;
      floor_glob[i] = '0;
      floor_stp[i]  = '0;
      last_rtt[i]   = '0;
    end

    // directed: zero samples on fresh and set minimums, field extremes,
    // restarts on both banks, small steps that exercise the truncation
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd0,        1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd1000,     1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd1000,     1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'hFFFFFFFF, 1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd1,        1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd0,        1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'hFFFFFFFF, 1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'hFFFFFFFF, 1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'd0,        1'b0);
    add_beat(OP_RESTART, BANK_HEADER, 32'hA5A5A5A5, 1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'd500,      1'b0);
    add_beat(OP_RESTART, BANK_DATA,   32'hFFFFFFFF, 1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'h55555555, 1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'hAAAAAAAA, 1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd7,        1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd9,        1'b0);
    add_beat(OP_RESTART, BANK_DATA,   32'd0,        1'b0);
    add_beat(OP_RESTART, BANK_DATA,   32'h5A5A5A5A, 1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'h80000000, 1'b0);
    add_beat(OP_SAMPLE,  BANK_DATA,   32'd0,        1'b0);
    add_beat(OP_SAMPLE,  BANK_HEADER, 32'd1,        1'b0);
    directed_n = sample_feed.size();

    // random part: mostly runs of jittered samples around a base on one bank,
    // often after a restart, mixed with fully random noise beats
    while (sample_feed.size() < directed_n + RANDOM_BEATS) begin
      bk = BANK_W'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len)
          add_beat(1'($urandom_range(0, 1)), BANK_W'($urandom_range(0, 1)), $urandom, 1'b0);
      end else begin
        if ($urandom_range(0, 3) == 0) add_beat(OP_RESTART, bk, $urandom, 1'b0);
        case ($urandom_range(0, 3))
          0:       base = longint'($urandom_range(1, 255));
          1:       base = longint'($urandom_range(256, 65535));
          2:       base = longint'($urandom_range(65536, 32'h00FFFFFF));
          default: base = longint'($urandom);
        endcase
        spread  = base / 4 + 1;
        run_len = $urandom_range(1, 20);
        repeat (run_len) begin
          case ($urandom_range(0, 49))
            0:       v = 0;
            1, 2:    v = longint'($urandom);
            default: v = base - spread / 2 + longint'($urandom_range(0, 32'(spread)));
          endcase
          if (v < 0) v = 0;
          if (v > RTT_TOP) v = RTT_TOP;
          add_beat(OP_SAMPLE, bk, v[31:0], 1'b0);
        end
      end
    end
    // the sender drains the block fully before the first random beat and now and then after
    sample_feed[directed_n].drain_first = 1'b1;
    for (int i = directed_n + 1; i < sample_feed.size(); i++)
      if ($urandom_range(0, 149) == 0) sample_feed[i].drain_first = 1'b1;
    total_beats = sample_feed.size();

    // synchronous reset, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_taken < total_beats) @(posedge clk);
    while (want_reports.size() != 0) @(posedge clk);
    // run on for DRAIN_CYCLES to catch any stray result beat
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && want_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
